// File: sv/u8u16_pkg.sv
`timescale 1ns / 1ps
package u8u16_pkg;

	// byte class boundaries
	localparam logic [7:0] ContMin  = 8'h80;
	localparam logic [7:0] Lead3Min = 8'hE0;
	localparam logic [7:0] Lead2Min = 8'hC0;
	localparam logic [7:0] Lead4Min = 8'hF0;
	localparam logic [7:0] BadMin   = 8'hF8;

	// code point limits
	localparam logic [20:0] BmpLowMax   = 21'h00D7FF;
	localparam logic [20:0] BmpHighMin  = 21'h00E000;
	localparam logic [20:0] BmpMax      = 21'h00FFFF;
	localparam logic [20:0] SuppMin     = 21'h010000;
	localparam logic [20:0] SuppMax     = 21'h10FFFF;
	localparam logic [15:0] HiSurrBase  = 16'hD800;
	localparam logic [15:0] LoSurrBase  = 16'hDC00;
	localparam logic [15:0] CapReset    = 16'hFFFF;

	// depth of the result queue
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);

	// one result item
	typedef struct packed {
		logic [15:0] code_unit;
		logic        unit_valid;
		logic        string_end;
	} res_t;

	// decoder state carried between bytes
	typedef struct packed {
		logic [20:0] code_accum;
		logic [1:0]  bytes_left;
		logic [1:0]  seq_length;
		logic [15:0] units_written;
		logic        discarding;
	} dec_state_t;

	// results of one byte
	typedef struct packed {
		logic [1:0] count;
		res_t       res0;
		res_t       res1;
	} dec_out_t;

endpackage

// File: sv/utf8_to_utf16_converter_unit.sv
`timescale 1ns / 1ps
// UTF-8 to UTF-16 stream converter. One byte is taken per cycle and decoded in
// the same cycle against the small sequence state; its zero, one or two UTF-16
// units go into a four-entry result queue that drives the output, one unit per
// cycle while m_tready is high. Input is accepted whenever the queue has room
// for two more results, so a steady stream runs at one byte per clock; a
// four-byte sequence with a surrogate pair gives the output two units for one.
// tlast marks the last result of a string (tuser low on a bare end marker).
// The user must write out_capacity only while the stream is idle (unchecked).
module utf8_to_utf16_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code_unit
	output logic        m_tuser,   // [0] unit_valid
	output logic        m_tlast,   // string_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // out_capacity
);
	import u8u16_pkg::*;

	localparam logic [QPtrW:0] QFreeNeed = (QPtrW + 1)'(QDepth - 2);

	dec_state_t         st_q;
	dec_state_t         st_nxt;
	dec_out_t           dec_res;
	logic [15:0]        cap_q;
	res_t               queue_q [QDepth];
	logic [QPtrW-1:0]   wr_ptr_q;
	logic [QPtrW-1:0]   rd_ptr_q;
	logic [QPtrW:0]     count_q;
	logic               in_req;
	logic               out_req;
	logic [QPtrW-1:0]   wr_ptr_p1;

	assign cfg_ready = 1'b1;
	assign s_tready  = count_q <= QFreeNeed;
	assign in_req    = s_tvalid && s_tready;
	assign m_tvalid  = count_q != '0;
	assign out_req   = m_tvalid && m_tready;
	assign wr_ptr_p1 = wr_ptr_q + QPtrW'(1);

	assign m_tdata = queue_q[rd_ptr_q].code_unit;
	assign m_tuser = queue_q[rd_ptr_q].unit_valid;
	assign m_tlast = queue_q[rd_ptr_q].string_end;

	u8u16_decoder u_dec (
		.in_byte      (s_tdata),
		.last_byte    (s_tlast),
		.out_capacity (cap_q),
		.cur          (st_q),
		.nxt          (st_nxt),
		.res          (dec_res)
	);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_req) begin
			st_q <= st_nxt;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_req) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(dec_res.count);
			end
			if (out_req) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			count_q <= count_q + (in_req ? (QPtrW + 1)'(dec_res.count) : '0)
				- (out_req ? (QPtrW + 1)'(1) : '0);
		end
	end

	// queue entries
	always_ff @(posedge clk) begin
		if (in_req && dec_res.count != 2'd0) begin
			queue_q[wr_ptr_q] <= dec_res.res0;
		end
		if (in_req && dec_res.count == 2'd2) begin
			queue_q[wr_ptr_p1] <= dec_res.res1;
		end
	end

endmodule

// File: sv/u8u16_decoder.sv
`timescale 1ns / 1ps
module u8u16_decoder (
	input  logic [7:0]            in_byte,
	input  logic                  last_byte,
	input  logic [15:0]           out_capacity,
	input  u8u16_pkg::dec_state_t cur,
	output u8u16_pkg::dec_state_t nxt,
	output u8u16_pkg::dec_out_t   res
);
	import u8u16_pkg::*;

	// decode one byte against the current state
	always_comb begin
		logic [20:0] v;
		logic [20:0] d;
		logic [15:0] u;
		logic        done;

		nxt  = cur;
		res  = '0;
		done = 1'b0;
		u    = cur.units_written;
		v    = '0;
		d    = '0;

		if (cur.discarding) begin
			// skip bytes after an early nul up to the marked last one
			nxt.discarding = ~last_byte;
			done = 1'b1;
		end else if (cur.bytes_left != 2'd0) begin
			// continuation byte, payload taken unchecked
			v = {cur.code_accum[14:0], in_byte[5:0]};
			nxt.code_accum = v;
			nxt.bytes_left = cur.bytes_left - 2'd1;
			if (cur.bytes_left == 2'd1) begin
				if (cur.seq_length == 2'd1) begin
					if (u < out_capacity) begin
						res.res0 = '{code_unit: v[15:0], unit_valid: 1'b1, string_end: 1'b0};
						res.count = 2'd1;
						u = u + 16'd1;
					end
				end else if (cur.seq_length == 2'd2) begin
					if ((v <= BmpLowMax || (v >= BmpHighMin && v <= BmpMax))
							&& u < out_capacity) begin
						res.res0 = '{code_unit: v[15:0], unit_valid: 1'b1, string_end: 1'b0};
						res.count = 2'd1;
						u = u + 16'd1;
					end
				end else if (cur.seq_length == 2'd3) begin
					// surrogate pair, the low half may be cut by capacity
					if (v >= SuppMin && v <= SuppMax && u < out_capacity) begin
						d = v - SuppMin;
						res.res0 = '{code_unit: HiSurrBase | {6'd0, d[19:10]},
							unit_valid: 1'b1, string_end: 1'b0};
						res.count = 2'd1;
						u = u + 16'd1;
						if (u < out_capacity) begin
							res.res1 = '{code_unit: LoSurrBase | {6'd0, d[9:0]},
								unit_valid: 1'b1, string_end: 1'b0};
							res.count = 2'd2;
							u = u + 16'd1;
						end
					end
				end
				nxt.code_accum = '0;
				nxt.seq_length = 2'd0;
			end
		end else if (in_byte == 8'd0) begin
			// nul lead ends the string with a bare marker
			res.res0 = '{code_unit: 16'd0, unit_valid: 1'b0, string_end: 1'b1};
			res.count = 2'd1;
			nxt.code_accum = '0;
			nxt.bytes_left = 2'd0;
			nxt.seq_length = 2'd0;
			u = '0;
			nxt.discarding = ~last_byte;
			done = 1'b1;
		end else if (in_byte < ContMin) begin
			// ascii passes through
			if (u < out_capacity) begin
				res.res0 = '{code_unit: {8'd0, in_byte}, unit_valid: 1'b1, string_end: 1'b0};
				res.count = 2'd1;
				u = u + 16'd1;
			end
		end else if (in_byte < Lead2Min) begin
			// stray continuation, skipped
		end else if (in_byte < Lead3Min) begin
			nxt.code_accum = {16'd0, in_byte[4:0]};
			nxt.bytes_left = 2'd1;
			nxt.seq_length = 2'd1;
		end else if (in_byte < Lead4Min) begin
			nxt.code_accum = {17'd0, in_byte[3:0]};
			nxt.bytes_left = 2'd2;
			nxt.seq_length = 2'd2;
		end else if (in_byte < BadMin) begin
			nxt.code_accum = {18'd0, in_byte[2:0]};
			nxt.bytes_left = 2'd3;
			nxt.seq_length = 2'd3;
		end

		// marked last byte closes the string
		if (!done && last_byte) begin
			if (res.count == 2'd2) begin
				res.res1.string_end = 1'b1;
			end else if (res.count == 2'd1) begin
				res.res0.string_end = 1'b1;
			end else begin
				res.res0 = '{code_unit: 16'd0, unit_valid: 1'b0, string_end: 1'b1};
				res.count = 2'd1;
			end
			nxt.code_accum = '0;
			nxt.bytes_left = 2'd0;
			nxt.seq_length = 2'd0;
			u = '0;
		end

		nxt.units_written = u;
	end

endmodule
